// ----- design/gpio_pulse_command_engine_core_macros.svh -----
// Assertion macros for the pulse command engine.
// Included by the modules that carry checks; needs signals named clk and rst.
`ifndef GPIO_PULSE_COMMAND_ENGINE_CORE_MACROS_SVH
`define GPIO_PULSE_COMMAND_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GPCE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpce assertion failed");
`define GPCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpce assertion failed");
`else
`define GPCE_ASSERT_IMPL(lbl, ante, cons)
`define GPCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/gpce_pkg.sv -----
// Shared types and codes of the pulse command engine.
// No dependencies; used by every module of the block.
package gpce_pkg;

  localparam int MAX_PINS   = 64;
  localparam int PIN_IDX_W  = $clog2(MAX_PINS);
  localparam int DUR_W      = 23;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

  localparam logic [DUR_W-1:0] MIN_DUR_RESET = DUR_W'(100);
  localparam logic [DUR_W-1:0] MAX_DUR_RESET = DUR_W'(5000000);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_PULSE  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] PH_REJECTED  = 2'd0;
  localparam logic [1:0] PH_ASSERTED  = 2'd1;
  localparam logic [1:0] PH_COMPLETED = 2'd2;
  localparam logic [1:0] PH_WRITE     = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_INSTANCE = 3'd1;
  localparam logic [2:0] ST_BAD_PIN      = 3'd2;
  localparam logic [2:0] ST_NOT_PULSE    = 3'd3;
  localparam logic [2:0] ST_BAD_DURATION = 3'd4;
  localparam logic [2:0] ST_NOT_WRITABLE = 3'd5;
  localparam logic [2:0] ST_BUSY         = 3'd6;

  localparam logic [2:0] REG_INSTANCE_ID  = 3'd0;
  localparam logic [2:0] REG_PIN_COUNT    = 3'd1;
  localparam logic [2:0] REG_WRITABLE     = 3'd2;
  localparam logic [2:0] REG_PULSE_ENABLE = 3'd3;
  localparam logic [2:0] REG_MIN_DUR      = 3'd4;
  localparam logic [2:0] REG_MAX_DUR      = 3'd5;

  typedef struct packed {
    logic [7:0]          instance_id;
    logic [6:0]          pin_count;
    logic [63:0]         writable_mask;
    logic [63:0]         pulse_enable_mask;
    logic [DUR_W-1:0]    min_length_us;
    logic [DUR_W-1:0]    max_length_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  status;
    logic [7:0]  inst;
    logic [15:0] pin;
    logic        level;
    logic [31:0] dur;
    logic [7:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          phase;
    logic [2:0]          status;
    logic [7:0]          inst;
    logic [15:0]         pin;
    logic [31:0]         dur;
    logic [7:0]          tag;
    logic [MAX_PINS-1:0] levels;
  } result_t;

endpackage

// ----- design/gpce_front.sv -----
// Front end: accepts requests, runs the configuration checks, queues them.
// Depends on gpce_pkg and the assertion macro header.
`include "gpio_pulse_command_engine_core_macros.svh"
module gpce_front (
  input  logic                clk,
  input  logic                rst,
  input  gpce_pkg::cfg_t      cfg,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          action,
  input  logic [15:0]         instance_req,
  input  logic [15:0]         pin_index,
  input  logic                level,
  input  logic [31:0]         length_us,
  input  logic [7:0]          tag,
  output gpce_pkg::cmd_t      head,
  output logic                head_valid,
  input  logic                head_pop
);

  gpce_pkg::cmd_t                cmdq [gpce_pkg::CMDQ_DEPTH];
  logic [gpce_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [gpce_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [gpce_pkg::CMDQ_PTR_W:0]   count;
  logic [gpce_pkg::CMDQ_PTR_W:0]   count_next;

  gpce_pkg::cmd_t                  cls;
  logic                            wr_en;
  logic                            pin_ok;
  logic                            dur_ok;
  logic [gpce_pkg::PIN_IDX_W-1:0]  pin_sel;

  assign in_full    = (count == (gpce_pkg::CMDQ_PTR_W+1)'(gpce_pkg::CMDQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = cmdq[rd_ptr];
  assign wr_en      = in_push && !in_full && (action != gpce_pkg::ACT_UNUSED);

  always_comb begin
    pin_sel = pin_index[gpce_pkg::PIN_IDX_W-1:0];
    pin_ok  = (pin_index < {9'b0, cfg.pin_count}) &&
              (pin_index < 16'(gpce_pkg::MAX_PINS));
    dur_ok  = !(length_us < {9'b0, cfg.min_length_us}) &&
              !(length_us > {9'b0, cfg.max_length_us}) &&
              (length_us != '0);
    cls.action = action;
    cls.inst   = instance_req[7:0];
    cls.pin    = pin_index;
    cls.level  = level;
    cls.dur    = length_us;
    cls.tag    = tag;
    cls.status = gpce_pkg::ST_OK;
    priority if (instance_req != {8'b0, cfg.instance_id}) begin
      cls.status = gpce_pkg::ST_BAD_INSTANCE;
    end else if (!pin_ok) begin
      cls.status = gpce_pkg::ST_BAD_PIN;
    end else if (action == gpce_pkg::ACT_PULSE && !cfg.pulse_enable_mask[pin_sel]) begin
      cls.status = gpce_pkg::ST_NOT_PULSE;
    end else if (action == gpce_pkg::ACT_PULSE && !dur_ok) begin
      cls.status = gpce_pkg::ST_BAD_DURATION;
    end else if (!cfg.writable_mask[pin_sel]) begin
      cls.status = gpce_pkg::ST_NOT_WRITABLE;
    end else begin
      cls.status = gpce_pkg::ST_OK;
    end
  end

  always_comb begin
    count_next = count;
    if (wr_en && !head_pop) begin
      count_next = count + 1'b1;
    end else if (!wr_en && head_pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (head_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cmdq[wr_ptr] <= cls;
    end
  end

  `GPCE_ASSERT_IMPL(a_no_write_when_full, wr_en, !in_full)
  `GPCE_ASSERT_IMPL(a_pop_needs_entry, head_pop, head_valid)
  `GPCE_ASSERT_NEXT(a_count_tracks, wr_en && !head_pop, count == $past(count) + 1'b1)

endmodule

// ----- design/gpce_back.sv -----
// Back end: owns pulse and pin state, executes queued requests, queues results.
// Depends on gpce_pkg and the assertion macro header.
`include "gpio_pulse_command_engine_core_macros.svh"
module gpce_back (
  input  logic                clk,
  input  logic                rst,
  input  gpce_pkg::cmd_t      head,
  input  logic                head_valid,
  output logic                head_pop,
  input  logic                res_pop,
  output logic                res_empty,
  output gpce_pkg::result_t   res_head
);

  logic                                 pulse_busy;
  logic                                 pulse_busy_next;
  logic [gpce_pkg::PIN_IDX_W-1:0]       pulse_pin;
  logic [gpce_pkg::PIN_IDX_W-1:0]       pulse_pin_next;
  logic [gpce_pkg::DUR_W-1:0]           remaining_us;
  logic [gpce_pkg::DUR_W-1:0]           remaining_us_next;
  logic [gpce_pkg::DUR_W-1:0]           pulse_length;
  logic [gpce_pkg::DUR_W-1:0]           pulse_length_next;
  logic [7:0]                           pulse_tag;
  logic [7:0]                           pulse_tag_next;
  logic [7:0]                           instance_held;
  logic [7:0]                           instance_held_next;
  logic [gpce_pkg::MAX_PINS-1:0]        output_levels;
  logic [gpce_pkg::MAX_PINS-1:0]        output_levels_next;

  gpce_pkg::result_t                    res;
  logic                                 emit;

  gpce_pkg::result_t                    resq [gpce_pkg::RESQ_DEPTH];
  logic [gpce_pkg::RESQ_PTR_W-1:0]      res_wr;
  logic [gpce_pkg::RESQ_PTR_W-1:0]      res_rd;
  logic [gpce_pkg::RESQ_PTR_W:0]        res_count;
  logic                                 res_push;
  logic                                 res_take;
  logic [gpce_pkg::PIN_IDX_W-1:0]       cmd_pin;

  assign head_pop  = head_valid &&
                     (res_count != (gpce_pkg::RESQ_PTR_W+1)'(gpce_pkg::RESQ_DEPTH));
  assign res_empty = (res_count == '0);
  assign res_head  = resq[res_rd];
  assign res_push  = head_pop && emit;
  assign res_take  = res_pop && !res_empty;
  assign cmd_pin   = head.pin[gpce_pkg::PIN_IDX_W-1:0];

  always_comb begin
    pulse_busy_next    = pulse_busy;
    pulse_pin_next     = pulse_pin;
    remaining_us_next  = remaining_us;
    pulse_length_next  = pulse_length;
    pulse_tag_next     = pulse_tag;
    instance_held_next = instance_held;
    output_levels_next = output_levels;
    emit               = 1'b0;
    res.phase          = gpce_pkg::PH_WRITE;
    res.status         = head.status;
    res.inst           = head.inst;
    res.pin            = head.pin;
    res.dur            = head.dur;
    res.tag            = head.tag;
    unique case (head.action)
      gpce_pkg::ACT_TICK: begin
        if (pulse_busy) begin
          if (remaining_us > gpce_pkg::DUR_W'(1)) begin
            remaining_us_next = remaining_us - 1'b1;
          end else begin
            remaining_us_next = '0;
            pulse_busy_next   = 1'b0;
            output_levels_next[pulse_pin] = 1'b0;
            emit       = 1'b1;
            res.phase  = gpce_pkg::PH_COMPLETED;
            res.status = gpce_pkg::ST_OK;
            res.inst   = instance_held;
            res.pin    = 16'(pulse_pin);
            res.dur    = 32'(pulse_length);
            res.tag    = pulse_tag;
          end
        end
      end
      gpce_pkg::ACT_WRITE: begin
        emit      = 1'b1;
        res.phase = gpce_pkg::PH_WRITE;
        res.dur   = '0;
        res.tag   = '0;
        if (head.status == gpce_pkg::ST_OK) begin
          output_levels_next[cmd_pin] = head.level;
        end
      end
      gpce_pkg::ACT_PULSE: begin
        emit = 1'b1;
        if (head.status != gpce_pkg::ST_OK) begin
          res.phase = gpce_pkg::PH_REJECTED;
        end else if (pulse_busy) begin
          res.phase  = gpce_pkg::PH_REJECTED;
          res.status = gpce_pkg::ST_BUSY;
        end else begin
          res.phase          = gpce_pkg::PH_ASSERTED;
          pulse_busy_next    = 1'b1;
          pulse_pin_next     = cmd_pin;
          remaining_us_next  = head.dur[gpce_pkg::DUR_W-1:0];
          pulse_length_next  = head.dur[gpce_pkg::DUR_W-1:0];
          pulse_tag_next     = head.tag;
          instance_held_next = head.inst;
          output_levels_next[cmd_pin] = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res.levels = output_levels_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_busy    <= 1'b0;
      pulse_pin     <= '0;
      remaining_us  <= '0;
      pulse_length  <= '0;
      pulse_tag     <= '0;
      instance_held <= '0;
      output_levels <= '0;
    end else if (head_pop) begin
      pulse_busy    <= pulse_busy_next;
      pulse_pin     <= pulse_pin_next;
      remaining_us  <= remaining_us_next;
      pulse_length  <= pulse_length_next;
      pulse_tag     <= pulse_tag_next;
      instance_held <= instance_held_next;
      output_levels <= output_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (res_push) begin
        res_wr <= res_wr + 1'b1;
      end
      if (res_take) begin
        res_rd <= res_rd + 1'b1;
      end
      if (res_push && !res_take) begin
        res_count <= res_count + 1'b1;
      end else if (!res_push && res_take) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      resq[res_wr] <= res;
    end
  end

  `GPCE_ASSERT_IMPL(a_idle_count_zero, !pulse_busy, remaining_us == '0)
  `GPCE_ASSERT_IMPL(a_busy_count_live, pulse_busy, remaining_us != '0)
  `GPCE_ASSERT_IMPL(a_resq_bound, 1'b1,
                    res_count <= (gpce_pkg::RESQ_PTR_W+1)'(gpce_pkg::RESQ_DEPTH))

endmodule

// ----- design/gpio_pulse_command_engine_core.sv -----
// Pulse command engine: one request per cycle in unless full, one result per cycle
// out unless empty. A request is registered in the request queue, its result (if any)
// in the result queue, which drives the ports. Four-entry request and two-entry result
// queues absorb stalls. The back end takes one request per cycle while resq has room.
// Reset (rst, synchronous): queues empty, all pins low, no pulse, registers to defaults.
// Depends on gpce_pkg, gpce_front and gpce_back.
module gpio_pulse_command_engine_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         push,
  output logic         full,
  input  logic [1:0]   action,
  input  logic [15:0]  instance_req,
  input  logic [15:0]  pin_index,
  input  logic         level,
  input  logic [31:0]  length_us,
  input  logic [7:0]   tag,
  output logic         empty,
  input  logic         pop,
  output logic [1:0]   phase,
  output logic [2:0]   status,
  output logic [7:0]   instance_out,
  output logic [15:0]  pin_out,
  output logic [31:0]  duration_out,
  output logic [7:0]   tag_out,
  output logic [63:0]  pin_levels
);

  gpce_pkg::cfg_t    cfg;
  gpce_pkg::cmd_t    head;
  logic              head_valid;
  logic              head_pop;
  gpce_pkg::result_t res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.instance_id       <= '0;
      cfg.pin_count         <= '0;
      cfg.writable_mask     <= '0;
      cfg.pulse_enable_mask <= '0;
      cfg.min_length_us     <= gpce_pkg::MIN_DUR_RESET;
      cfg.max_length_us     <= gpce_pkg::MAX_DUR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpce_pkg::REG_INSTANCE_ID:  cfg.instance_id       <= cfg_data[7:0];
        gpce_pkg::REG_PIN_COUNT:    cfg.pin_count         <= cfg_data[6:0];
        gpce_pkg::REG_WRITABLE:     cfg.writable_mask     <= cfg_data;
        gpce_pkg::REG_PULSE_ENABLE: cfg.pulse_enable_mask <= cfg_data;
        gpce_pkg::REG_MIN_DUR:
          cfg.min_length_us <= cfg_data[gpce_pkg::DUR_W-1:0];
        gpce_pkg::REG_MAX_DUR:
          cfg.max_length_us <= cfg_data[gpce_pkg::DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gpce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_push      (push),
    .in_full      (full),
    .action       (action),
    .instance_req (instance_req),
    .pin_index    (pin_index),
    .level        (level),
    .length_us    (length_us),
    .tag          (tag),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop)
  );

  gpce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .res_pop    (pop),
    .res_empty  (empty),
    .res_head   (res_head)
  );

  assign phase        = res_head.phase;
  assign status       = res_head.status;
  assign instance_out = res_head.inst;
  assign pin_out      = res_head.pin;
  assign duration_out = res_head.dur;
  assign tag_out      = res_head.tag;
  assign pin_levels   = 64'(res_head.levels);

endmodule
